// ===== hw/rtl/swha_pkg.sv =====
package swha_pkg;

   localparam int unsigned WordWidth = 64;
   localparam int unsigned ByteCount = 8;

   localparam logic [WordWidth-1:0] SEED_WORDS = 64'h0000_0000_0dec_0ded;
   localparam logic [WordWidth-1:0] SEED_BYTES = 64'h0000_0000_0de7_a115;
   localparam logic [WordWidth-1:0] SEED_RESET = SEED_WORDS;

   typedef logic [7:0] byte_type;

   // bit position taken from each input byte before the rotation by output byte
   localparam logic [2:0] BIT_BASE [ByteCount] = '{
      3'd6, 3'd4, 3'd7, 3'd3, 3'd0, 3'd1, 3'd5, 3'd2
   };

   localparam byte_type SBOX_A [256] = '{
      8'd245, 8'd184, 8'd171, 8'd36,  8'd93,  8'd194, 8'd192, 8'd143,
      8'd207, 8'd89,  8'd63,  8'd175, 8'd203, 8'd231, 8'd47,  8'd238,
      8'd103, 8'd67,  8'd176, 8'd102, 8'd80,  8'd133, 8'd24,  8'd155,
      8'd91,  8'd141, 8'd234, 8'd58,  8'd44,  8'd191, 8'd218, 8'd157,
      8'd13,  8'd168, 8'd160, 8'd113, 8'd211, 8'd213, 8'd252, 8'd236,
      8'd2,   8'd19,  8'd21,  8'd148, 8'd111, 8'd251, 8'd165, 8'd74,
      8'd124, 8'd25,  8'd181, 8'd210, 8'd250, 8'd195, 8'd235, 8'd97,
      8'd185, 8'd1,   8'd179, 8'd198, 8'd105, 8'd101, 8'd5,   8'd220,
      8'd35,  8'd162, 8'd142, 8'd41,  8'd200, 8'd209, 8'd224, 8'd71,
      8'd201, 8'd134, 8'd69,  8'd48,  8'd65,  8'd170, 8'd72,  8'd167,
      8'd145, 8'd205, 8'd28,  8'd88,  8'd215, 8'd81,  8'd214, 8'd78,
      8'd118, 8'd26,  8'd123, 8'd84,  8'd140, 8'd49,  8'd45,  8'd8,
      8'd7,   8'd107, 8'd227, 8'd60,  8'd59,  8'd32,  8'd30,  8'd82,
      8'd31,  8'd189, 8'd131, 8'd17,  8'd66,  8'd239, 8'd64,  8'd10,
      8'd149, 8'd40,  8'd130, 8'd146, 8'd54,  8'd147, 8'd9,   8'd114,
      8'd4,   8'd254, 8'd241, 8'd116, 8'd110, 8'd249, 8'd57,  8'd233,
      8'd37,  8'd55,  8'd206, 8'd100, 8'd177, 8'd119, 8'd139, 8'd158,
      8'd108, 8'd75,  8'd94,  8'd23,  8'd186, 8'd152, 8'd244, 8'd27,
      8'd38,  8'd33,  8'd188, 8'd87,  8'd76,  8'd166, 8'd228, 8'd52,
      8'd120, 8'd99,  8'd247, 8'd174, 8'd51,  8'd183, 8'd3,   8'd161,
      8'd246, 8'd135, 8'd14,  8'd178, 8'd11,  8'd216, 8'd77,  8'd172,
      8'd122, 8'd154, 8'd39,  8'd253, 8'd104, 8'd34,  8'd164, 8'd230,
      8'd219, 8'd242, 8'd68,  8'd151, 8'd180, 8'd115, 8'd173, 8'd73,
      8'd212, 8'd90,  8'd125, 8'd29,  8'd22,  8'd221, 8'd56,  8'd121,
      8'd255, 8'd204, 8'd83,  8'd169, 8'd182, 8'd112, 8'd96,  8'd187,
      8'd20,  8'd106, 8'd79,  8'd15,  8'd61,  8'd223, 8'd70,  8'd85,
      8'd53,  8'd197, 8'd217, 8'd232, 8'd196, 8'd95,  8'd136, 8'd150,
      8'd243, 8'd109, 8'd129, 8'd202, 8'd208, 8'd237, 8'd144, 8'd156,
      8'd86,  8'd127, 8'd62,  8'd248, 8'd138, 8'd229, 8'd153, 8'd226,
      8'd240, 8'd199, 8'd50,  8'd12,  8'd193, 8'd98,  8'd137, 8'd126,
      8'd0,   8'd159, 8'd222, 8'd18,  8'd163, 8'd117, 8'd190, 8'd46,
      8'd225, 8'd132, 8'd16,  8'd43,  8'd128, 8'd42,  8'd92,  8'd6
   };

   localparam byte_type SBOX_B [256] = '{
      8'd0,   8'd202, 8'd239, 8'd108, 8'd121, 8'd122, 8'd197, 8'd193,
      8'd220, 8'd75,  8'd79,  8'd208, 8'd162, 8'd157, 8'd40,  8'd95,
      8'd138, 8'd223, 8'd51,  8'd42,  8'd151, 8'd165, 8'd3,   8'd133,
      8'd18,  8'd227, 8'd232, 8'd125, 8'd114, 8'd41,  8'd10,  8'd23,
      8'd178, 8'd29,  8'd43,  8'd106, 8'd167, 8'd203, 8'd61,  8'd100,
      8'd250, 8'd247, 8'd1,   8'd253, 8'd105, 8'd81,  8'd205, 8'd82,
      8'd63,  8'd149, 8'd92,  8'd89,  8'd117, 8'd221, 8'd96,  8'd181,
      8'd177, 8'd252, 8'd152, 8'd135, 8'd64,  8'd150, 8'd28,  8'd132,
      8'd236, 8'd46,  8'd5,   8'd7,   8'd255, 8'd38,  8'd243, 8'd175,
      8'd248, 8'd242, 8'd171, 8'd212, 8'd67,  8'd186, 8'd57,  8'd86,
      8'd15,  8'd211, 8'd47,  8'd218, 8'd113, 8'd207, 8'd134, 8'd11,
      8'd128, 8'd97,  8'd169, 8'd52,  8'd4,   8'd101, 8'd198, 8'd159,
      8'd54,  8'd224, 8'd222, 8'd161, 8'd91,  8'd182, 8'd238, 8'd209,
      8'd139, 8'd76,  8'd142, 8'd254, 8'd36,  8'd80,  8'd111, 8'd219,
      8'd229, 8'd26,  8'd93,  8'd22,  8'd9,   8'd195, 8'd185, 8'd200,
      8'd226, 8'd126, 8'd107, 8'd237, 8'd183, 8'd251, 8'd44,  8'd94,
      8'd234, 8'd166, 8'd112, 8'd53,  8'd188, 8'd120, 8'd30,  8'd213,
      8'd68,  8'd190, 8'd25,  8'd78,  8'd102, 8'd244, 8'd37,  8'd153,
      8'd20,  8'd141, 8'd103, 8'd90,  8'd62,  8'd98,  8'd144, 8'd21,
      8'd155, 8'd230, 8'd34,  8'd189, 8'd176, 8'd59,  8'd191, 8'd168,
      8'd130, 8'd87,  8'd201, 8'd214, 8'd192, 8'd73,  8'd164, 8'd246,
      8'd13,  8'd124, 8'd140, 8'd58,  8'd110, 8'd14,  8'd145, 8'd137,
      8'd179, 8'd217, 8'd85,  8'd2,   8'd19,  8'd8,   8'd154, 8'd104,
      8'd196, 8'd84,  8'd65,  8'd147, 8'd206, 8'd16,  8'd123, 8'd160,
      8'd240, 8'd60,  8'd127, 8'd235, 8'd99,  8'd199, 8'd216, 8'd6,
      8'd204, 8'd156, 8'd118, 8'd225, 8'd56,  8'd83,  8'd158, 8'd143,
      8'd71,  8'd66,  8'd163, 8'd173, 8'd116, 8'd172, 8'd228, 8'd249,
      8'd49,  8'd48,  8'd69,  8'd210, 8'd184, 8'd70,  8'd74,  8'd241,
      8'd88,  8'd24,  8'd194, 8'd174, 8'd35,  8'd17,  8'd32,  8'd33,
      8'd231, 8'd77,  8'd148, 8'd119, 8'd233, 8'd27,  8'd136, 8'd115,
      8'd39,  8'd170, 8'd12,  8'd180, 8'd31,  8'd55,  8'd187, 8'd50,
      8'd109, 8'd131, 8'd45,  8'd129, 8'd146, 8'd215, 8'd72,  8'd245
   };

endpackage

// ===== hw/rtl/sbox_word_hash_accumulator.sv =====
// Word hash accumulator.
// The request channel (req_valid/req_ready) carries one 64-bit word and a
// last-word flag. Each word is mixed through two S-box layers and XORed into
// a running accumulator. On a word marked last, the response channel
// (rsp_valid/rsp_ready) delivers the accumulated hash and the accumulator is
// reloaded from the seed register.
// The CSR channel (csr_valid/csr_ready, always ready) writes the seed and
// loads the accumulator with it at once; write it only while no request is
// in flight.
// Throughput: one request per cycle while req_ready is high. The last word
// sits in the input register, then the mix and accumulate land in the
// response register that drives rsp_*.
// Reset sets the seed and accumulator to 0xdec0ded and empties both stages.
// When the receiver stalls, a waiting hash holds in the response register;
// words without a result keep flowing, and a second last word waits in the
// input register, which then holds req_ready low.
module sbox_word_hash_accumulator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_seed
);
   import swha_pkg::*;

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [WordWidth-1:0] in_word_ff;
   logic                 in_last_ff;
   logic [WordWidth-1:0] seed_ff;
   logic [WordWidth-1:0] acc_ff;
   logic [WordWidth-1:0] acc_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [WordWidth-1:0] rsp_hash_ff;
   logic [WordWidth-1:0] mixed;
   logic [WordWidth-1:0] acc_sum;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;
   logic                 csr_take;

   function automatic logic [WordWidth-1:0] mix_word(input logic [WordWidth-1:0] w);
      byte_type             idx;
      byte_type             b [ByteCount];
      byte_type             x;
      logic [2:0]           pos;
      logic [WordWidth-1:0] r;
      x = '0;
      r = '0;
      for (int k = 0; k < ByteCount; k++) begin
         idx = '0;
         for (int i = 0; i < ByteCount; i++) begin
            pos      = BIT_BASE[i] + 3'(k);
            idx[pos] = idx[pos] ^ w[8*i + int'(pos)];
         end
         b[k] = SBOX_A[idx];
         x    = x ^ b[k];
      end
      // each output byte is the XOR of the other seven, translated
      for (int k = 0; k < ByteCount; k++) begin
         r[WordWidth-1-8*k -: 8] = SBOX_B[x ^ b[k]];
      end
      return r;
   endfunction

   assign mixed    = mix_word(in_word_ff);
   assign acc_sum  = acc_ff ^ mixed;
   assign out_free = !rsp_valid_ff || rsp_ready;
   // a word without a result never waits on the response side
   assign advance  = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end

      acc_in = acc_ff;
      if (advance) begin
         acc_in = in_last_ff ? seed_ff : acc_sum;
      end
      if (csr_take) begin
         acc_in = csr_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= SEED_RESET;
         acc_ff       <= SEED_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         if (csr_take) begin
            seed_ff <= csr_seed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_data_word;
         in_last_ff <= req_last_word;
      end
      if (advance && in_last_ff) begin
         rsp_hash_ff <= acc_sum;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

endmodule

// ===== tb/sv/tb_sbox_word_hash_accumulator.sv =====
`timescale 1ns / 1ps

module tb_sbox_word_hash_accumulator;
   import swha_pkg::*;

   class hash_scoreboard;
      logic [63:0] seed_value;
      logic [63:0] acc;
      logic [63:0] hashes_due[$];
      int          mismatches;

      function new();
         seed_value = SEED_RESET;
         acc        = SEED_RESET;
         mismatches = 0;
      endfunction

      function logic [63:0] mix_word(logic [63:0] w);
         byte_type    b [8];
         byte_type    x;
         byte_type    idx;
         logic [63:0] r;
         int          k;
         int          i;
         x = 8'd0;
         r = 64'd0;
         for (k = 0; k < 8; k++) begin
            idx = 8'd0;
            // gather one rotated bit from every input byte, in place
            for (i = 0; i < 8; i++)
               idx ^= w[8*i +: 8] & (8'd1 << ((int'(BIT_BASE[i]) + k) & 7));
            b[k] = SBOX_A[idx];
            x ^= b[k];
         end
         for (k = 0; k < 8; k++)
            r[8*(7-k) +: 8] = SBOX_B[x ^ b[k]];
         return r;
      endfunction

      function void load_seed(logic [63:0] v);
         seed_value = v;
         acc        = v;
      endfunction

      function void note_word(logic [63:0] w, logic last);
         acc ^= mix_word(w);
         if (last) begin
            hashes_due.push_back(acc);
            acc = seed_value;
         end
      endfunction

      function void check_hash(logic [63:0] actual);
         logic [63:0] want;
         if (hashes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected hash %h with nothing pending", actual);
            return;
         end
         want = hashes_due.pop_front();
         if (actual !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("hash_value mismatch: expected %h, actual %h", want, actual);
         end
      endfunction

      function int pending();
         return hashes_due.size();
      endfunction
   endclass

   localparam int unsigned CycleLimit = 1000000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [63:0] req_data_word  = 64'd0;
   logic        req_last_word  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [63:0] rsp_hash_value;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [63:0] csr_seed       = 64'd0;

   hash_scoreboard sb = new();

   bit          req_gaps_on  = 1'b0;
   bit          rsp_stall_on = 1'b0;
   int          rsp_hold_len = 0;
   int unsigned cycles       = 0;

   sbox_word_hash_accumulator DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb_sbox_word_hash_accumulator: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.load_seed(csr_seed);
         if (req_valid && req_ready)
            sb.note_word(req_data_word, req_last_word);
         if (rsp_valid && rsp_ready)
            sb.check_hash(rsp_hash_value);
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // response side: random stalls, plus a long hold-off on demand
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
            n = pick_gap();
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // leaves req_valid high after the request is taken
   task automatic send_word(input logic [63:0] w, input logic last);
      int gap;
      gap = 0;
      if (req_gaps_on && $urandom_range(0, 2) == 0)
         gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_word <= w;
      req_last_word <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] v);
      drain();
      // let a word with no hash clear the pipeline
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_seed  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] random_word(bit byte_mode);
      int sel;
      if (byte_mode)
         return {56'd0, 8'($urandom)};
      sel = $urandom_range(0, 19);
      if (sel == 0)
         return 64'd0;
      if (sel == 1)
         return '1;
      if (sel == 2)
         return 64'd1 << $urandom_range(0, 63);
      return {$urandom, $urandom};
   endfunction

   initial begin
      int          phase;
      int          sent;
      int          len;
      int          j;
      bit          byte_mode;
      logic [63:0] seed_pick;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset seed, extremes, multi-word sets
      send_word(64'd0, 1'b1);
      send_word('1, 1'b1);
      send_word(64'd1, 1'b0);
      send_word(64'h8000_0000_0000_0000, 1'b0);
      send_word(64'h0123_4567_89ab_cdef, 1'b1);
      send_word(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
      send_word(64'h5555_5555_5555_5555, 1'b1);
      // seed write drops the set under way
      send_word(64'hdead_beef_cafe_f00d, 1'b0);
      send_word(64'h0f0f_0f0f_0f0f_0f0f, 1'b0);
      write_seed(SEED_BYTES);
      send_word({56'd0, 8'h00}, 1'b0);
      send_word({56'd0, 8'hff}, 1'b0);
      send_word({56'd0, 8'h7f}, 1'b1);
      write_seed(64'd0);
      send_word(64'd0, 1'b1);
      send_word(64'h0000_0000_0000_0080, 1'b1);
      write_seed('1);
      send_word('1, 1'b1);
      send_word(64'd0, 1'b0);
      send_word(64'hffff_ffff_0000_0000, 1'b1);

      for (phase = 0; phase < 8; phase++) begin
         byte_mode = (phase == 3 || phase == 6);
         case (phase)
            0: seed_pick = SEED_WORDS;
            1: seed_pick = '1;
            2: seed_pick = 64'd0;
            3: seed_pick = SEED_BYTES;
            default: seed_pick = {$urandom, $urandom};
         endcase
         write_seed(seed_pick);
         req_gaps_on  = (phase % 2 == 1) || phase == 4;
         rsp_stall_on = (phase % 3 != 0);
         if (phase == 2) begin
            // stall the receiver while the sender keeps pushing
            req_gaps_on  = 1'b0;
            rsp_hold_len = 80;
         end
         sent = 0;
         while (sent < 250) begin
            if ($urandom_range(0, 9) == 0)
               len = $urandom_range(9, 24);
            else if ($urandom_range(0, 2) == 0)
               len = 1;
            else
               len = $urandom_range(2, 8);
            for (j = 0; j < len; j++)
               send_word(random_word(byte_mode), j == len - 1);
            sent += len;
            if ($urandom_range(0, 39) == 0)
               drain();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0)
         $display("tb_sbox_word_hash_accumulator: clean");
      else
         $display("tb_sbox_word_hash_accumulator: errors");
      $finish;
   end

endmodule

// ===== sbox_word_hash_accumulator.f =====
hw/rtl/swha_pkg.sv
hw/rtl/sbox_word_hash_accumulator.sv
tb/sv/tb_sbox_word_hash_accumulator.sv
